// ----- sv/running_excess_kurtosis_defines.svh -----
// ----------------------------------------------------------------------------
// running_excess_kurtosis_defines.svh
// Assertion macros shared by the kurtosis block's checker.
// ----------------------------------------------------------------------------
`ifndef RUNNING_EXCESS_KURTOSIS_DEFINES_SVH
`define RUNNING_EXCESS_KURTOSIS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define REK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rek assertion failed");

// next-cycle implication, disabled during reset
`define REK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rek assertion failed");

`endif

// ----- sv/rek_pkg.sv -----
// ----------------------------------------------------------------------------
// rek_pkg
// Types, constants and saturating helpers for the running kurtosis block.
// ----------------------------------------------------------------------------
package rek_pkg;

  localparam int unsigned MEAN_FRAC   = 24;
  localparam int unsigned M2_FRAC     = 12;
  localparam int unsigned M3_FRAC     = 10;
  localparam int unsigned M4_FRAC     = 8;
  localparam int unsigned OUT_FRAC    = 16;
  localparam int unsigned RATIO_SHIFT = OUT_FRAC + 2 * M2_FRAC - M4_FRAC;

  localparam logic [127:0] QUOT_CAP   = 128'd1 << 40;
  localparam logic [63:0]  THREE_Q16  = 64'd3 << OUT_FRAC;
  localparam logic [63:0]  KURT_MAX   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0]  S64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]  S64_MIN    = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_ISSUE, ST_MUL, ST_UPD, ST_FIN, ST_RDGO, ST_RDIV, ST_OUT
  } state_t;

  // multiplier micro-ops, issued in this order
  typedef enum logic [3:0] {
    OP_R2, OP_A, OP_T, OP_POL, OP_B, OP_Q4A, OP_C, OP_C6,
    OP_E, OP_E4, OP_F, OP_Q3A, OP_G, OP_G3, OP_NUM, OP_DEN
  } op_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] v;
  } sres_t;

  function automatic sres_t sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    sres_t       r;
    s = {a[63], a} + {b[63], b};
    r.sat = s[64] ^ s[63];
    r.v   = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sres_t sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    sres_t       r;
    s = {a[63], a} - {b[63], b};
    r.sat = s[64] ^ s[63];
    r.v   = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

endpackage

// ----- sv/rek_mul.sv -----
// ----------------------------------------------------------------------------
// rek_mul
// Shared 64x64 signed multiplier: four 32x32 partial products, then a
// floor shift by k with saturation to signed 64.
// ----------------------------------------------------------------------------
module rek_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  input  logic [4:0]   k,
  output logic         done,
  output logic [127:0] prod,   // raw magnitude product
  output logic [63:0]  res,    // floored, saturated result
  output logic         sat
);

  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [4:0]   k_r;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]   ph_r, ph_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [63:0]  res_r, res_nxt;
  logic         sat_r, sat_nxt;
  logic [63:0]  pp;
  logic [6:0]   shamt;
  logic [127:0] sh, mag;
  logic         frac;

  always_comb begin
    case (ph_r[1:0])
      2'd0: begin pp = ua_r[31:0] * ub_r[31:0];   shamt = 7'd0;  end
      2'd1: begin pp = ua_r[31:0] * ub_r[63:32];  shamt = 7'd32; end
      2'd2: begin pp = ua_r[63:32] * ub_r[31:0];  shamt = 7'd32; end
      default: begin pp = ua_r[63:32] * ub_r[63:32]; shamt = 7'd64; end
    endcase
  end

  always_comb begin
    sh   = acc_r >> k_r;
    frac = |(acc_r & ((128'd1 << k_r) - 128'd1));
    mag  = sh + 128'(frac);
    if (!neg_r) begin
      sat_nxt = (sh[127:63] != '0);
      res_nxt = sat_nxt ? rek_pkg::S64_MAX : sh[63:0];
    end else begin
      sat_nxt = (mag[127:64] != '0) || (mag[63:0] > rek_pkg::S64_MIN);
      res_nxt = sat_nxt ? rek_pkg::S64_MIN : (64'd0 - mag[63:0]);
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      ph_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ph_r == 3'd4) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        acc_nxt = acc_r + ({64'd0, pp} << shamt);
        ph_nxt  = ph_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
    acc_r <= acc_nxt;
    if (start) begin
      ua_r  <= a[63] ? 64'd0 - a : a;
      ub_r  <= b[63] ? 64'd0 - b : b;
      neg_r <= a[63] ^ b[63];
      k_r   <= k;
    end
    if (busy_r && ph_r == 3'd4) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule

// ----- sv/rek_div.sv -----
// ----------------------------------------------------------------------------
// rek_div
// Restoring unsigned divider, 128-bit numerator and divisor, one quotient
// bit per cycle; the caller picks the number of steps.
// ----------------------------------------------------------------------------
module rek_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [127:0] den,
  input  logic [7:0]   steps,
  output logic         done,
  output logic [127:0] quot
);

  logic [127:0] rem_r, num_r, den_r, q_r;
  logic [7:0]   cnt_r;
  logic         busy_r, done_r;
  logic [128:0] remsh, diff;
  logic         ge;

  assign remsh = {rem_r, num_r[127]};
  assign diff  = remsh - {1'b0, den_r};
  assign ge    = (remsh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[127:0] : remsh[127:0];
      num_r <= {num_r[126:0], 1'b0};
      q_r   <= {q_r[126:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- sv/running_excess_kurtosis.sv -----
// ----------------------------------------------------------------------------
// running_excess_kurtosis
// Streaming excess kurtosis with one-pass fixed-point moment updates.
// ----------------------------------------------------------------------------
// Per sample: a 64-step divide by n, then 14 ops on the shared 64x64 multiplier, then one update.
// A last sample of a usable set adds two multiplies and a 128-step divide.
// A new sample is taken only once the previous one is done; in_tready is high only when idle.
// Reset: rst_n synchronous, active low; clears count, mean, moments, flags.
// ----------------------------------------------------------------------------
module running_excess_kurtosis #(
  parameter int COUNT_BITS  = 20,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  // input stream
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                     in_tlast,   // last sample of the set
  // result stream
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((32 + COUNT_BITS + 7) / 8) * 8 - 1:0] out_tdata, // [31:0] excess_kurtosis,
                                                                  // then sample_count
  output logic                                     out_tuser   // invalid
);

  localparam int OUT_W = ((32 + COUNT_BITS + 7) / 8) * 8;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  rek_pkg::state_t state_r, state_nxt;
  rek_pkg::op_t    op_r, op_nxt;

  // per-set statistics
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [63:0] mean_r, mean_nxt, m2_r, m2_nxt, m3_r, m3_nxt, m4_r, m4_nxt;
  logic        ovf_r, ovf_nxt;
  // per-sample scratch
  logic        sat_r, sat_nxt, last_r, last_nxt, bad_r, bad_nxt;
  logic [63:0] dev_r, dev_nxt, r_r, r_nxt, r2_r, r2_nxt, t_r, t_nxt;
  logic [63:0] pol_r, pol_nxt, tmp_r, tmp_nxt, q4_r, q4_nxt, q3_r, q3_nxt;
  logic [127:0] num_r, num_nxt, den_r, den_nxt;
  logic [31:0] kurt_r, kurt_nxt;
  // output register
  logic                  ovalid_r, ovalid_nxt, oinv_r, oinv_nxt;
  logic [31:0]           okurt_r, okurt_nxt;
  logic [COUNT_BITS-1:0] ocnt_r, ocnt_nxt;

  // shared units
  logic         mul_start, mul_done, mul_sat;
  logic [63:0]  mul_a, mul_b, mul_res;
  logic [4:0]   mul_k;
  logic [127:0] mul_prod;
  logic         div_start, div_done;
  logic [127:0] div_num, div_den, div_quot;
  logic [7:0]   div_steps;

  logic [63:0]  n64, i64, s64, dev_in, dev_mag, qdiv, qcap;
  rek_pkg::sres_t sa, sb, sc;

  assign i64     = 64'(count_r);
  assign n64     = i64 + 64'd1;
  assign s64     = 64'(signed'(in_tdata[SAMPLE_BITS-1:0]));
  assign dev_in  = (s64 << rek_pkg::MEAN_FRAC) - mean_r;
  assign dev_mag = dev_in[63] ? 64'd0 - dev_in : dev_in;
  assign qdiv    = div_quot[63:0];
  assign qcap    = (div_quot > rek_pkg::QUOT_CAP) ? rek_pkg::QUOT_CAP[63:0] : qdiv;

  assign in_tready = (state_r == rek_pkg::ST_IDLE);

  // operand select for the current micro-op
  always_comb begin
    mul_a = r_r;
    mul_b = r_r;
    mul_k = 5'd0;
    case (op_r)
      rek_pkg::OP_R2:  begin mul_a = r_r;   mul_b = r_r;          mul_k = 5'd24; end
      rek_pkg::OP_A:   begin mul_a = dev_r; mul_b = r_r;          mul_k = 5'd24; end
      rek_pkg::OP_T:   begin mul_a = tmp_r; mul_b = i64;                         end
      rek_pkg::OP_POL: begin mul_a = n64;   mul_b = n64 - 64'd3;                 end
      rek_pkg::OP_B:   begin mul_a = r2_r;  mul_b = pol_r;                       end
      rek_pkg::OP_Q4A: begin mul_a = t_r;   mul_b = tmp_r;        mul_k = 5'd24; end
      rek_pkg::OP_C:   begin mul_a = r2_r;  mul_b = m2_r;         mul_k = 5'd12; end
      rek_pkg::OP_C6:  begin mul_a = tmp_r; mul_b = 64'd6;                       end
      rek_pkg::OP_E:   begin mul_a = r_r;   mul_b = m3_r;         mul_k = 5'd10; end
      rek_pkg::OP_E4:  begin mul_a = tmp_r; mul_b = 64'd4;                       end
      rek_pkg::OP_F:   begin mul_a = r_r;   mul_b = n64 - 64'd2;                 end
      rek_pkg::OP_Q3A: begin mul_a = t_r;   mul_b = tmp_r;        mul_k = 5'd24; end
      rek_pkg::OP_G:   begin mul_a = r_r;   mul_b = m2_r;         mul_k = 5'd12; end
      rek_pkg::OP_G3:  begin mul_a = tmp_r; mul_b = 64'd3;                       end
      rek_pkg::OP_NUM: begin mul_a = i64;   mul_b = m4_r;                        end
      rek_pkg::OP_DEN: begin mul_a = m2_r;  mul_b = m2_r;                        end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    count_nxt  = count_r;
    mean_nxt   = mean_r;
    m2_nxt     = m2_r;
    m3_nxt     = m3_r;
    m4_nxt     = m4_r;
    ovf_nxt    = ovf_r;
    sat_nxt    = sat_r;
    last_nxt   = last_r;
    bad_nxt    = bad_r;
    dev_nxt    = dev_r;
    r_nxt      = r_r;
    r2_nxt     = r2_r;
    t_nxt      = t_r;
    pol_nxt    = pol_r;
    tmp_nxt    = tmp_r;
    q4_nxt     = q4_r;
    q3_nxt     = q3_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    kurt_nxt   = kurt_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    okurt_nxt  = okurt_r;
    ocnt_nxt   = ocnt_r;
    oinv_nxt   = oinv_r;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    div_num    = {dev_mag, 64'd0};
    div_den    = {64'd0, n64};
    div_steps  = 8'd64;
    sa         = rek_pkg::sat_add(q4_r, mul_res);
    sb         = rek_pkg::sat_sub(q4_r, mul_res);
    sc         = rek_pkg::sat_sub(q3_r, mul_res);

    case (state_r)
      rek_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          last_nxt = in_tlast;
          if (count_r == CMAX) begin
            // full count: sample dropped, set is marked bad
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? rek_pkg::ST_FIN : rek_pkg::ST_IDLE;
          end else begin
            dev_nxt   = dev_in;
            sat_nxt   = 1'b0;
            div_start = 1'b1;
            state_nxt = rek_pkg::ST_DIV;
          end
        end
      end
      rek_pkg::ST_DIV: begin
        if (div_done) begin
          r_nxt     = dev_r[63] ? 64'd0 - qdiv : qdiv;   // truncate toward zero
          op_nxt    = rek_pkg::OP_R2;
          state_nxt = rek_pkg::ST_ISSUE;
        end
      end
      rek_pkg::ST_ISSUE: begin
        mul_start = 1'b1;
        state_nxt = rek_pkg::ST_MUL;
      end
      rek_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = rek_pkg::ST_ISSUE;
          op_nxt    = rek_pkg::op_t'(op_r + 4'd1);
          if (op_r != rek_pkg::OP_POL && op_r != rek_pkg::OP_NUM &&
              op_r != rek_pkg::OP_DEN) begin
            sat_nxt = sat_r | mul_sat;
          end
          case (op_r)
            rek_pkg::OP_R2:  r2_nxt  = mul_res;
            rek_pkg::OP_A:   tmp_nxt = mul_res;
            rek_pkg::OP_T:   t_nxt   = mul_res;
            rek_pkg::OP_POL: begin
              // n*n - 3n + 3, taken as 1 below n = 3
              if (n64 < 64'd3) begin
                pol_nxt = 64'd1;
              end else begin
                pol_nxt = rek_pkg::sat_add(mul_res, 64'd3).v;
                sat_nxt = sat_r | mul_sat | rek_pkg::sat_add(mul_res, 64'd3).sat;
              end
            end
            rek_pkg::OP_B:   tmp_nxt = mul_res;
            rek_pkg::OP_Q4A: q4_nxt  = mul_res;
            rek_pkg::OP_C:   tmp_nxt = mul_res;
            rek_pkg::OP_C6:  begin q4_nxt = sa.v; sat_nxt = sat_r | mul_sat | sa.sat; end
            rek_pkg::OP_E:   tmp_nxt = mul_res;
            rek_pkg::OP_E4:  begin q4_nxt = sb.v; sat_nxt = sat_r | mul_sat | sb.sat; end
            rek_pkg::OP_F:   tmp_nxt = mul_res;
            rek_pkg::OP_Q3A: q3_nxt  = mul_res;
            rek_pkg::OP_G:   tmp_nxt = mul_res;
            rek_pkg::OP_G3:  begin
              q3_nxt    = sc.v;
              sat_nxt   = sat_r | mul_sat | sc.sat;
              state_nxt = rek_pkg::ST_UPD;
            end
            rek_pkg::OP_NUM: num_nxt = mul_prod;
            rek_pkg::OP_DEN: begin
              den_nxt   = mul_prod;
              state_nxt = rek_pkg::ST_RDGO;
            end
            default: ;
          endcase
        end
      end
      rek_pkg::ST_UPD: begin
        // moment sums take the floored deltas; mean wraps
        m4_nxt    = rek_pkg::sat_add(m4_r, $signed(q4_r) >>> 16).v;
        m3_nxt    = rek_pkg::sat_add(m3_r, $signed(q3_r) >>> 14).v;
        m2_nxt    = rek_pkg::sat_add(m2_r, $signed(t_r) >>> 12).v;
        mean_nxt  = mean_r + r_r;
        count_nxt = count_r + COUNT_BITS'(1);
        ovf_nxt   = ovf_r | sat_r
                  | rek_pkg::sat_add(m4_r, $signed(q4_r) >>> 16).sat
                  | rek_pkg::sat_add(m3_r, $signed(q3_r) >>> 14).sat
                  | rek_pkg::sat_add(m2_r, $signed(t_r) >>> 12).sat;
        state_nxt = last_r ? rek_pkg::ST_FIN : rek_pkg::ST_IDLE;
      end
      rek_pkg::ST_FIN: begin
        if (ovf_r || count_r < COUNT_BITS'(2) || $signed(m2_r) <= 64'sd0) begin
          bad_nxt   = 1'b1;
          kurt_nxt  = '0;
          state_nxt = rek_pkg::ST_OUT;
        end else if ($signed(m4_r) <= 64'sd0) begin
          bad_nxt   = 1'b0;
          kurt_nxt  = 32'd0 - rek_pkg::THREE_Q16[31:0];
          state_nxt = rek_pkg::ST_OUT;
        end else begin
          bad_nxt   = 1'b0;
          op_nxt    = rek_pkg::OP_NUM;
          state_nxt = rek_pkg::ST_ISSUE;
        end
      end
      rek_pkg::ST_RDGO: begin
        div_start = 1'b1;
        div_num   = num_r << rek_pkg::RATIO_SHIFT;
        div_den   = den_r;
        div_steps = 8'd128;
        state_nxt = rek_pkg::ST_RDIV;
      end
      rek_pkg::ST_RDIV: begin
        if (div_done) begin
          if (qcap >= rek_pkg::KURT_MAX + rek_pkg::THREE_Q16) begin
            kurt_nxt = rek_pkg::KURT_MAX[31:0];
          end else begin
            kurt_nxt = qcap[31:0] - rek_pkg::THREE_Q16[31:0];
          end
          state_nxt = rek_pkg::ST_OUT;
        end
      end
      rek_pkg::ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          okurt_nxt  = kurt_r;
          ocnt_nxt   = count_r;
          oinv_nxt   = bad_r;
          count_nxt  = '0;
          mean_nxt   = '0;
          m2_nxt     = '0;
          m3_nxt     = '0;
          m4_nxt     = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = rek_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rek_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rek_pkg::ST_IDLE;
      op_r     <= rek_pkg::OP_R2;
      count_r  <= '0;
      mean_r   <= '0;
      m2_r     <= '0;
      m3_r     <= '0;
      m4_r     <= '0;
      ovf_r    <= 1'b0;
      sat_r    <= 1'b0;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      count_r  <= count_nxt;
      mean_r   <= mean_nxt;
      m2_r     <= m2_nxt;
      m3_r     <= m3_nxt;
      m4_r     <= m4_nxt;
      ovf_r    <= ovf_nxt;
      sat_r    <= sat_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
    end
    bad_r   <= bad_nxt;
    dev_r   <= dev_nxt;
    r_r     <= r_nxt;
    r2_r    <= r2_nxt;
    t_r     <= t_nxt;
    pol_r   <= pol_nxt;
    tmp_r   <= tmp_nxt;
    q4_r    <= q4_nxt;
    q3_r    <= q3_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    kurt_r  <= kurt_nxt;
    okurt_r <= okurt_nxt;
    ocnt_r  <= ocnt_nxt;
    oinv_r  <= oinv_nxt;
  end

  rek_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .k     (mul_k),
    .done  (mul_done),
    .prod  (mul_prod),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  rek_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OUT_W'({ocnt_r, okurt_r});
  assign out_tuser  = oinv_r;

endmodule

// ----- sv/rek_checker.sv -----
// ----------------------------------------------------------------------------
// rek_checker
// Port-level assertions for the running kurtosis block, bound to the top.
// ----------------------------------------------------------------------------
`include "running_excess_kurtosis_defines.svh"

module rek_checker #(
  parameter int COUNT_BITS  = 20,
  parameter int SAMPLE_BITS = 24
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input logic in_tlast,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((32 + COUNT_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input logic out_tuser
);

  // a waiting input transaction holds its payload
  `REK_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready, in_tvalid && $stable({in_tlast, in_tdata}))
  // a stalled transaction holds its payload
  `REK_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // an invalid set reports zero kurtosis
  `REK_ASSERT_NOW(a_inv_zero, out_tvalid && out_tuser, out_tdata[31:0] == 32'd0)
  // a valid set has at least two samples
  `REK_ASSERT_NOW(a_cnt_min, out_tvalid && !out_tuser, out_tdata[32 +: COUNT_BITS] >= COUNT_BITS'(2))
  // a new result only comes out of a busy period
  `REK_ASSERT_NOW(a_out_busy, $rose(out_tvalid), $past(!in_tready))

endmodule

bind running_excess_kurtosis rek_checker #(
  .COUNT_BITS  (COUNT_BITS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rek_checker (.*);
